[hdl/snks_pkg.sv]
// Package for the sorted node nearest-key search block.
// Field widths, opcodes, relation codes, register map and transaction types.
// No dependencies.
package snks_pkg;

    // Default sizing, handed to the top level parameters
    localparam int NODE_KEYS_DEF = 64;
    localparam int KEY_BITS_DEF  = 32;

    // Fixed field widths of the channels
    localparam int INDEX_W = 6;
    localparam int KEY_W   = 32;
    localparam int COUNT_W = 7;
    localparam int SLOT_W  = 6;
    localparam int REL_W   = 2;

    // APB register port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_KEY_COUNT = 1'b0;   // word index of key_count

    // Operation codes
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    // Relation codes
    localparam logic [REL_W-1:0] REL_EXACT   = 2'd0;
    localparam logic [REL_W-1:0] REL_LESS    = 2'd1;
    localparam logic [REL_W-1:0] REL_GREATER = 2'd2;

    // Request transaction
    typedef struct packed {
        logic               operation;
        logic [INDEX_W-1:0] index;
        logic [KEY_W-1:0]   key_value;
        logic               want_less;
        logic               want_greater;
    } t_req;

    // Response transaction
    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] slot;
        logic [REL_W-1:0]  relation;
    } t_rsp;

endpackage

[hdl/snks_chan_if.sv]
// Valid/ready channel interface carrying one payload type.
// Used for request and response channels; payload types come from snks_pkg.
interface snks_chan_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[hdl/snks_cfg_regs.sv]
// APB register file for the search block: holds key_count.
// Depends on snks_pkg.
module snks_cfg_regs import snks_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [COUNT_W-1:0]    o_key_count
);

    logic               w_wr;
    logic               w_sel_count;
    logic [COUNT_W-1:0] r_key_count;

    // Word decode on the top address bit
    assign w_sel_count = (paddr[APB_ADDR_W-1] == REG_KEY_COUNT);
    assign w_wr        = psel && penable && pwrite;
    assign pready      = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_count <= '0;
        end else if (w_wr && w_sel_count) begin
            r_key_count <= pwdata[COUNT_W-1:0];
        end
    end

    // Read back
    assign prdata      = w_sel_count ? APB_DATA_W'(r_key_count) : '0;
    assign o_key_count = r_key_count;

endmodule

[hdl/snks_key_ram.sv]
// Key store: one write port, one read port with registered read data.
// No dependencies.
module snks_key_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/snks_seq.sv]
// Search sequencer: takes request transactions, writes keys, and runs the
// binary search one probe per cycle through a single compare unit.
// Depends on snks_pkg and snks_chan_if.
module snks_seq import snks_pkg::*; #(
    parameter int NODE_KEYS = NODE_KEYS_DEF,
    parameter int KEY_BITS  = KEY_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    snks_chan_if.sink                    i_req,
    snks_chan_if.source                  o_rsp,
    input  logic [COUNT_W-1:0]           i_key_count,
    output logic                         o_we,
    output logic [$clog2(NODE_KEYS)-1:0] o_waddr,
    output logic [KEY_BITS-1:0]          o_wdata,
    output logic [$clog2(NODE_KEYS)-1:0] o_raddr,
    input  logic [KEY_BITS-1:0]          i_rdata
);

    localparam int AW = $clog2(NODE_KEYS);
    localparam int CW = $clog2(NODE_KEYS + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_STEP,
        S_EMIT
    } t_state;

    t_state              r_state, n_state;
    logic [CW-1:0]       r_lo, n_lo;
    logic [CW-1:0]       r_hi, n_hi;
    logic [CW-1:0]       r_cnt, n_cnt;
    logic                r_eq, n_eq;
    logic [KEY_BITS-1:0] r_key, n_key;
    logic                r_less, n_less;
    logic                r_greater, n_greater;
    t_rsp                r_res, n_res;
    logic                r_out_valid;
    t_rsp                r_out;

    t_req                w_req;
    logic                w_accept;
    logic [CW-1:0]       w_n;
    logic [CW-1:0]       w_mid;
    logic [CW-1:0]       w_next_mid;
    logic [CW-1:0]       w_f;
    logic                w_le;
    logic                w_load;

    assign w_req    = i_req.data;
    assign i_req.ready = (r_state == S_IDLE);
    assign w_accept = i_req.valid && i_req.ready;

    // Key count saturated at the node size
    always_comb begin
        if (32'(i_key_count) > 32'(NODE_KEYS)) begin
            w_n = CW'(NODE_KEYS);
        end else begin
            w_n = CW'(i_key_count);
        end
    end

    // Key writes go straight to the store; out-of-range slots are dropped
    assign o_we    = w_accept && (w_req.operation == OP_WRITE)
                     && (32'(w_req.index) < 32'(NODE_KEYS));
    assign o_waddr = AW'(w_req.index);
    assign o_wdata = KEY_BITS'(w_req.key_value);

    // Shared compare unit on the probed key
    assign w_mid = r_lo + ((r_hi - r_lo) >> 1);
    assign w_le  = (i_rdata <= r_key);

    // Output register is free or being drained
    assign w_load = (r_state == S_EMIT) && (!r_out_valid || o_rsp.ready);

    always_comb begin
        n_state   = r_state;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_cnt     = r_cnt;
        n_eq      = r_eq;
        n_key     = r_key;
        n_less    = r_less;
        n_greater = r_greater;
        n_res     = r_res;
        w_f       = '0;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept && (w_req.operation == OP_SEARCH)) begin
                    n_key     = KEY_BITS'(w_req.key_value);
                    n_less    = w_req.want_less;
                    n_greater = w_req.want_greater;
                    n_cnt     = w_n;
                    n_lo      = '0;
                    n_hi      = w_n;
                    n_eq      = 1'b0;
                    if (w_n == '0) begin
                        // empty node
                        n_res   = '{found: 1'b0, slot: '0, relation: REL_EXACT};
                        n_state = S_EMIT;
                    end else begin
                        n_state = S_STEP;
                    end
                end
            end
            S_STEP: begin
                // one probe per cycle; eq tracks the last probe at or below the key
                if (w_le) begin
                    n_lo = CW'(w_mid + 1'b1);
                    n_eq = (i_rdata == r_key);
                end else begin
                    n_hi = w_mid;
                end
                if (n_lo == n_hi) begin
                    n_state = S_EMIT;
                    w_f     = CW'(n_lo - 1'b1);
                    if (n_lo == '0) begin
                        // key below every stored key
                        if (r_greater) begin
                            n_res = '{found: 1'b1, slot: '0, relation: REL_GREATER};
                        end else begin
                            n_res = '{found: 1'b0, slot: '0, relation: REL_EXACT};
                        end
                    end else if (n_eq) begin
                        n_res = '{found: 1'b1, slot: SLOT_W'(w_f), relation: REL_EXACT};
                    end else if (r_less) begin
                        n_res = '{found: 1'b1, slot: SLOT_W'(w_f), relation: REL_LESS};
                    end else if (r_greater && (n_lo < r_cnt)) begin
                        n_res = '{found: 1'b1, slot: SLOT_W'(n_lo),
                                  relation: REL_GREATER};
                    end else begin
                        n_res = '{found: 1'b0, slot: '0, relation: REL_EXACT};
                    end
                end
            end
            S_EMIT: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Next probe address, read this edge so data is ready next cycle
    assign w_next_mid = n_lo + ((n_hi - n_lo) >> 1);
    assign o_raddr    = AW'(w_next_mid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_cnt     <= n_cnt;
        r_eq      <= n_eq;
        r_key     <= n_key;
        r_less    <= n_less;
        r_greater <= n_greater;
        r_res     <= n_res;
        if (w_load) begin
            r_out <= r_res;
        end
    end

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

endmodule

[hdl/sorted_node_nearest_key_search.sv]
// Sorted node nearest-key search. A search accepts the request, then runs the
// binary-search probes, one key-store read each (floor(log2(key_count))+1 at
// most, 7 for 64 keys), then loads the output register once it is free.
// Synchronous active-low reset clears key_count and control; key store is not cleared.
module sorted_node_nearest_key_search import snks_pkg::*; #(
    parameter int NODE_KEYS = NODE_KEYS_DEF,
    parameter int KEY_BITS  = KEY_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    snks_chan_if.sink             i_req,
    snks_chan_if.source           o_rsp,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int AW = $clog2(NODE_KEYS);

    logic [COUNT_W-1:0]  w_key_count;
    logic                w_we;
    logic [AW-1:0]       w_waddr;
    logic [KEY_BITS-1:0] w_wdata;
    logic [AW-1:0]       w_raddr;
    logic [KEY_BITS-1:0] w_rdata;

    // Register port
    snks_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_key_count (w_key_count)
    );

    // Key store
    snks_key_ram #(
        .DEPTH (NODE_KEYS),
        .WIDTH (KEY_BITS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Search sequencer
    snks_seq #(
        .NODE_KEYS (NODE_KEYS),
        .KEY_BITS  (KEY_BITS)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_rsp       (o_rsp),
        .i_key_count (w_key_count),
        .o_we        (w_we),
        .o_waddr     (w_waddr),
        .o_wdata     (w_wdata),
        .o_raddr     (w_raddr),
        .i_rdata     (w_rdata)
    );

    // A miss carries slot 0 and the exact code
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.data.found)
        |-> (o_rsp.data.slot == '0) && (o_rsp.data.relation == REL_EXACT))
        else $error("miss transaction with nonzero slot or relation");

    // A key write never raises a response
    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready && (i_req.data.operation == OP_WRITE)
         && !o_rsp.valid)
        |=> !o_rsp.valid)
        else $error("response raised by a key write");

    // The block is busy right after taking a search
    a_search_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready && (i_req.data.operation == OP_SEARCH))
        |=> !i_req.ready)
        else $error("request taken during a search");

endmodule

[dv/tb_sorted_node_nearest_key_search.sv]
// Self-checking testbench for sorted_node_nearest_key_search: directed and random
// write/search transactions with random stalls, checked against a local predictor.
// Depends on hdl/snks_pkg.sv, hdl/snks_chan_if.sv and the top-level RTL.
`timescale 1ns / 1ps

module tb_sorted_node_nearest_key_search;
    import snks_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int unsigned RANDOM_ITEMS = 1000;
    localparam logic [APB_ADDR_W-1:0] KEY_COUNT_ADDR = {REG_KEY_COUNT, 2'b00};

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    snks_chan_if #(.T(t_req)) req_if ();
    snks_chan_if #(.T(t_rsp)) rsp_if ();

    sorted_node_nearest_key_search u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Predictor state: node contents and key count as the block should hold them
    logic [KEY_W-1:0]   node_keys [NODE_KEYS_DEF];
    logic [COUNT_W-1:0] node_count;

    t_req        queued_reqs[$];
    t_rsp        expected_matches[$];
    int unsigned error_count;
    int unsigned cycle_count;
    int unsigned req_gap;
    int unsigned rsp_stall;
    logic        quiet;

    // Clock, 20 ns period
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Idle length: mostly none or short, a few long
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (quiet) return 0;
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Floor search over the first key_count slots, with the neighbor rules
    function automatic t_rsp search_node(input logic [KEY_W-1:0] key,
                                         input logic want_less, input logic want_greater);
        int unsigned n;
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        t_rsp        r;
        r  = '0;
        n  = (node_count > NODE_KEYS_DEF) ? NODE_KEYS_DEF : node_count;
        if (n == 0) return r;
        lo = 0;
        hi = n;
        while (lo < hi) begin
            mid = lo + ((hi - lo) >> 1);
            if (node_keys[mid] <= key) lo = mid + 1;
            else hi = mid;
        end
        if (lo == 0) begin
            // key below slot 0
            if (want_greater) begin
                r.found    = 1'b1;
                r.relation = REL_GREATER;
            end
            return r;
        end
        if (node_keys[lo-1] == key) begin
            r.found    = 1'b1;
            r.slot     = SLOT_W'(lo - 1);
            r.relation = REL_EXACT;
        end else if (want_less) begin
            r.found    = 1'b1;
            r.slot     = SLOT_W'(lo - 1);
            r.relation = REL_LESS;
        end else if (want_greater && lo < n) begin
            r.found    = 1'b1;
            r.slot     = SLOT_W'(lo);
            r.relation = REL_GREATER;
        end
        return r;
    endfunction

    function automatic void flag_error(input string msg);
        if (error_count < 10) $display("%0t ERROR: %s", $realtime, msg);
        error_count++;
    endfunction

    // Request driver; predicts each accepted transaction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
            req_gap      <= 0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                if (req_if.data.operation == OP_WRITE)
                    node_keys[req_if.data.index] = req_if.data.key_value;
                else
                    expected_matches.push_back(search_node(req_if.data.key_value,
                        req_if.data.want_less, req_if.data.want_greater));
            end
            if (!req_if.valid || req_if.ready) begin
                if (req_gap != 0) begin
                    req_if.valid <= 1'b0;
                    req_gap      <= req_gap - 1;
                end else if (queued_reqs.size() != 0) begin
                    req_if.data  <= queued_reqs.pop_front();
                    req_if.valid <= 1'b1;
                    req_gap      <= pick_gap();
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // Response back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
            rsp_stall    <= 0;
        end else if (rsp_stall != 0) begin
            rsp_if.ready <= 1'b0;
            rsp_stall    <= rsp_stall - 1;
        end else begin
            rsp_if.ready <= 1'b1;
            rsp_stall    <= pick_gap();
        end
    end

    // Response monitor
    always @(posedge i_clk) begin : rsp_monitor
        t_rsp want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (expected_matches.size() == 0) begin
                flag_error($sformatf("unexpected response found=%0b slot=%0d rel=%0d",
                    rsp_if.data.found, rsp_if.data.slot, rsp_if.data.relation));
            end else begin
                want = expected_matches.pop_front();
                if (rsp_if.data.found !== want.found || rsp_if.data.slot !== want.slot ||
                        rsp_if.data.relation !== want.relation)
                    flag_error($sformatf({"response mismatch: exp found=%0b slot=%0d rel=%0d,",
                        " got found=%0b slot=%0d rel=%0d"}, want.found, want.slot,
                        want.relation, rsp_if.data.found, rsp_if.data.slot,
                        rsp_if.data.relation));
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic queue_req(input logic op, input logic [INDEX_W-1:0] idx,
                             input logic [KEY_W-1:0] key, input logic want_less,
                             input logic want_greater);
        t_req r;
        r.operation    = op;
        r.index        = idx;
        r.key_value    = key;
        r.want_less    = want_less;
        r.want_greater = want_greater;
        queued_reqs.push_back(r);
    endtask

    // Wait until every transaction is out and answered, then let a trailing write retire
    task automatic wait_drained();
        do @(negedge i_clk);
        while (queued_reqs.size() != 0 || req_if.valid || expected_matches.size() != 0);
        repeat (12) @(negedge i_clk);
    endtask

    task automatic apb_write(input logic [APB_ADDR_W-1:0] addr,
                             input logic [APB_DATA_W-1:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == KEY_COUNT_ADDR) node_count = data[COUNT_W-1:0];
    endtask

    // Stimulus
    initial begin
        logic [KEY_W-1:0]  dir_keys [8];
        logic [KEY_W-1:0]  phase_keys [NODE_KEYS_DEF];
        logic [KEY_W-1:0]  key;
        logic [KEY_W-1:0]  tmp;
        logic [INDEX_W-1:0] idx;
        longint unsigned   cur;
        longint unsigned   span;
        int unsigned       cnt;
        int unsigned       n;
        int unsigned       mode;
        int unsigned       sel;
        int unsigned       j;
        int unsigned       a;
        int unsigned       b;
        int unsigned       phase;
        int unsigned       rand_items;

        i_rst_n      = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        req_if.valid = 1'b0;
        req_if.data  = '0;
        rsp_if.ready = 1'b0;
        node_count   = '0;
        error_count  = 0;
        cycle_count  = 0;
        quiet        = 1'b0;
        dir_keys     = '{32'd16, 32'd32, 32'd48, 32'd48, 32'd64, 32'd80, 32'd96,
                         32'hFFFF_FFFF};

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Empty node: never found, whatever the request bits
        queue_req(OP_SEARCH, 6'd0, 32'h0, 1'b1, 1'b1);
        queue_req(OP_SEARCH, 6'd0, 32'hFFFF_FFFF, 1'b0, 1'b1);
        queue_req(OP_SEARCH, 6'd63, 32'h0, 1'b1, 1'b0);
        queue_req(OP_SEARCH, 6'd0, 32'h8000_0000, 1'b0, 1'b0);
        // Small node with a duplicate pair and the top key value
        for (int i = 0; i < 8; i++)
            queue_req(OP_WRITE, INDEX_W'(i), dir_keys[i], 1'b0, 1'b0);
        wait_drained();
        apb_write(KEY_COUNT_ADDR, 32'd8);

        // Below every key
        queue_req(OP_SEARCH, 6'd0, 32'd0, 1'b1, 1'b0);
        queue_req(OP_SEARCH, 6'd0, 32'd0, 1'b1, 1'b1);
        queue_req(OP_SEARCH, 6'd0, 32'd5, 1'b0, 1'b1);
        queue_req(OP_SEARCH, 6'd0, 32'd0, 1'b0, 1'b0);
        // Exact hits: duplicate returns the later slot, first and top key
        queue_req(OP_SEARCH, 6'd0, 32'd48, 1'b0, 1'b0);
        queue_req(OP_SEARCH, 6'd0, 32'd16, 1'b0, 1'b0);
        queue_req(OP_SEARCH, 6'd0, 32'hFFFF_FFFF, 1'b0, 1'b0);
        // Between keys, every request combination
        queue_req(OP_SEARCH, 6'd0, 32'd50, 1'b1, 1'b0);
        queue_req(OP_SEARCH, 6'd0, 32'd50, 1'b0, 1'b1);
        queue_req(OP_SEARCH, 6'd0, 32'd50, 1'b0, 1'b0);
        queue_req(OP_SEARCH, 6'd0, 32'd50, 1'b1, 1'b1);
        queue_req(OP_SEARCH, 6'd0, 32'hFFFF_FFFE, 1'b0, 1'b1);
        wait_drained();

        // Above the last key with only want_greater: not found
        apb_write(KEY_COUNT_ADDR, 32'd7);
        queue_req(OP_SEARCH, 6'd0, 32'd1000, 1'b0, 1'b1);
        queue_req(OP_SEARCH, 6'd0, 32'hFFFF_FFFE, 1'b0, 1'b1);
        wait_drained();

        // Random phases: fill a sorted node, set the count, then mostly searches
        phase      = 0;
        rand_items = 0;
        while (rand_items < RANDOM_ITEMS) begin
            case (phase)
                0:       cnt = 64;
                1:       cnt = 127;
                2:       cnt = 1;
                3:       cnt = 2;
                4:       cnt = 0;
                default: cnt = ($urandom_range(0, 6) == 0) ? $urandom_range(65, 127)
                                                           : $urandom_range(1, 64);
            endcase
            quiet = (phase % 4 == 3);
            n     = (cnt > NODE_KEYS_DEF) ? NODE_KEYS_DEF : cnt;

            // Sorted contents: dense with duplicates, spread over the range, or near the top
            mode = $urandom_range(0, 3);
            span = 64'hFFFF_FFFF / (n + 1);
            case (mode)
                0:       cur = 64'($urandom_range(0, 1000));
                3:       cur = 64'hFFFF_FFFF - 4 * n;
                default: cur = 64'($urandom_range(0, 32'(span)));
            endcase
            for (int i = 0; i < n; i++) begin
                phase_keys[i] = cur[KEY_W-1:0];
                case (mode)
                    0:       cur += 64'($urandom_range(0, 3));
                    3:       cur += 64'($urandom_range(0, 4));
                    default: cur += 64'($urandom_range(1, 32'(span)));
                endcase
            end
            // Occasionally an unsorted node
            if (n >= 2 && $urandom_range(0, 7) == 0) begin
                a             = $urandom_range(0, n - 1);
                b             = $urandom_range(0, n - 1);
                tmp           = phase_keys[a];
                phase_keys[a] = phase_keys[b];
                phase_keys[b] = tmp;
            end
            for (int i = 0; i < n; i++)
                queue_req(OP_WRITE, INDEX_W'(i), phase_keys[i], 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)));
            rand_items += n;
            wait_drained();
            apb_write(KEY_COUNT_ADDR, cnt);

            for (int i = 0; i < 60; i++) begin
                if ($urandom_range(0, 99) < 15) begin
                    // Write: mostly rewrites the same value, sometimes scrambles the order
                    idx = INDEX_W'($urandom_range(0, NODE_KEYS_DEF - 1));
                    key = $urandom();
                    if (idx < n && $urandom_range(0, 3) != 0) key = phase_keys[idx];
                    if (idx < n) phase_keys[idx] = key;
                    queue_req(OP_WRITE, idx, key, 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)));
                end else begin
                    sel = $urandom_range(0, 9);
                    if (n == 0 || sel < 2) begin
                        key = $urandom();
                    end else begin
                        j = $urandom_range(0, n - 1);
                        case (sel)
                            2, 3, 4: key = phase_keys[j];
                            5, 6:    key = phase_keys[j] - 1'b1;
                            7, 8:    key = phase_keys[j] + 1'b1;
                            default: key = j[0] ? '1 : '0;
                        endcase
                    end
                    queue_req(OP_SEARCH, INDEX_W'($urandom_range(0, NODE_KEYS_DEF - 1)), key,
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                end
            end
            rand_items += 60;
            wait_drained();
            phase++;
        end

        quiet = 1'b0;
        wait_drained();
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
